// ===== rtl/dsd_pkg.sv =====
`default_nettype none

package dsd_pkg;

  // Default sizing of the dictionary.
  localparam int MAX_WORDS_DEF  = 16;
  localparam int WORD_BYTES_DEF = 32;

  // Marker bytes of the message format.
  localparam logic [7:0] CH_END_HEADER = 8'h3E;
  localparam logic [7:0] CH_SEPARATOR  = 8'h2C;
  localparam logic [7:0] CH_ESCAPE     = 8'h40;

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_INDEX = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic hdr_close;     // close the word being collected
    logic hdr_write;     // store the input byte in the current word
    logic emit_overflow; // load an overflow error result
    logic emit_literal;  // load the input byte as a literal result
    logic emit_bad;      // load a bad-index error result
    logic exp_start;     // latch the word and prime the memory reads
    logic exp_emit;      // load the next word byte and advance
    logic msg_restart;   // clear word count and write position
  } dsd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_sep;        // input byte is a separator
    logic is_end;        // input byte ends the header
    logic is_esc;        // input byte is the escape marker
    logic hdr_overflow;  // word full or word table full
    logic idx_bad;       // index byte is zero or beyond the word count
    logic exp_last;      // current word byte is the final one
    logic out_free;      // output register can take a result this cycle
  } dsd_stat_t;

endpackage

`default_nettype wire

// ===== rtl/dsd_datapath.sv =====
`default_nettype none

module dsd_datapath #(
  parameter int MAX_WORDS  = dsd_pkg::MAX_WORDS_DEF,
  parameter int WORD_BYTES = dsd_pkg::WORD_BYTES_DEF
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire  [7:0]       in_byte,
  input  dsd_pkg::dsd_cmd_t cmd,
  output dsd_pkg::dsd_stat_t stat,
  output logic             out_valid,
  input  wire              out_ready,
  output logic [7:0]       out_byte,
  output logic             out_last,
  output logic [1:0]       out_status
);

  localparam int DEPTH = MAX_WORDS * WORD_BYTES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WIW   = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int WCW   = $clog2(MAX_WORDS + 1);
  localparam int PW    = $clog2(WORD_BYTES + 1);

  logic [7:0]     dict_mem [DEPTH];
  logic [PW-1:0]  len_mem  [MAX_WORDS];

  logic [WCW-1:0] word_count_r, word_count_nxt;
  logic [PW-1:0]  wpos_r, wpos_nxt;
  logic [AW-1:0]  exp_base_r, exp_base_nxt;
  logic [PW-1:0]  exp_pos_r, exp_pos_nxt;
  logic [7:0]     dict_rd_r;
  logic [PW-1:0]  len_rd_r;

  logic           out_valid_r;
  logic [7:0]     out_byte_r;
  logic           out_last_r;
  logic [1:0]     out_status_r;

  logic [WIW-1:0] idx_w;
  logic [AW-1:0]  idx_base;
  logic [AW-1:0]  wr_addr;
  logic [AW-1:0]  rd_addr;
  logic           load;

  assign idx_w    = WIW'(in_byte - 8'd1);
  assign idx_base = AW'(idx_w) * AW'(WORD_BYTES);
  assign wr_addr  = AW'(word_count_r[WIW-1:0]) * AW'(WORD_BYTES) + AW'(wpos_r);

  always_comb begin
    stat.is_sep       = (in_byte == dsd_pkg::CH_SEPARATOR);
    stat.is_end       = (in_byte == dsd_pkg::CH_END_HEADER);
    stat.is_esc       = (in_byte == dsd_pkg::CH_ESCAPE);
    stat.hdr_overflow = (word_count_r >= WCW'(MAX_WORDS)) || (wpos_r >= PW'(WORD_BYTES));
    stat.idx_bad      = (in_byte == 8'd0) || (9'(in_byte) > 9'(word_count_r));
    stat.exp_last     = ((exp_pos_r + PW'(1)) == len_rd_r);
    stat.out_free     = !out_valid_r || out_ready;
  end

  // Word count and write position of the header.
  always_comb begin
    word_count_nxt = word_count_r;
    wpos_nxt       = wpos_r;
    if (cmd.msg_restart) begin
      word_count_nxt = '0;
      wpos_nxt       = '0;
    end else if (cmd.hdr_close) begin
      if ((wpos_r != '0) && (word_count_r < WCW'(MAX_WORDS))) begin
        word_count_nxt = word_count_r + WCW'(1);
      end
      wpos_nxt = '0;
    end else if (cmd.hdr_write) begin
      wpos_nxt = wpos_r + PW'(1);
    end
  end

  // Expansion pointer; the read address runs one step ahead of the output.
  always_comb begin
    exp_base_nxt = exp_base_r;
    exp_pos_nxt  = exp_pos_r;
    if (cmd.exp_start) begin
      exp_base_nxt = idx_base;
      exp_pos_nxt  = '0;
    end else if (cmd.exp_emit) begin
      exp_pos_nxt = exp_pos_r + PW'(1);
    end
    rd_addr = exp_base_nxt + AW'(exp_pos_nxt);
  end

  assign load = cmd.emit_overflow || cmd.emit_literal || cmd.emit_bad || cmd.exp_emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_count_r <= '0;
      wpos_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      word_count_r <= word_count_nxt;
      wpos_r       <= wpos_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    exp_base_r <= exp_base_nxt;
    exp_pos_r  <= exp_pos_nxt;
    if (load) begin
      if (cmd.exp_emit) begin
        out_byte_r   <= dict_rd_r;
        out_last_r   <= stat.exp_last;
        out_status_r <= dsd_pkg::ST_OK;
      end else if (cmd.emit_literal) begin
        out_byte_r   <= in_byte;
        out_last_r   <= 1'b1;
        out_status_r <= dsd_pkg::ST_OK;
      end else if (cmd.emit_bad) begin
        out_byte_r   <= 8'd0;
        out_last_r   <= 1'b1;
        out_status_r <= dsd_pkg::ST_BAD_INDEX;
      end else begin
        out_byte_r   <= 8'd0;
        out_last_r   <= 1'b1;
        out_status_r <= dsd_pkg::ST_OVERFLOW;
      end
    end
  end

  // Dictionary bytes: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.hdr_write) begin
      dict_mem[wr_addr] <= in_byte;
    end
    dict_rd_r <= dict_mem[rd_addr];
  end

  // Word lengths: written on close, read once at expansion start.
  always_ff @(posedge clk) begin
    if (cmd.hdr_close && !cmd.msg_restart && (wpos_r != '0) &&
        (word_count_r < WCW'(MAX_WORDS))) begin
      len_mem[word_count_r[WIW-1:0]] <= wpos_r;
    end
    if (cmd.exp_start) begin
      len_rd_r <= len_mem[idx_w];
    end
  end

  assign out_valid  = out_valid_r;
  assign out_byte   = out_byte_r;
  assign out_last   = out_last_r;
  assign out_status = out_status_r;

endmodule

`default_nettype wire

// ===== rtl/dsd_controller.sv =====
`default_nettype none

module dsd_controller (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  input  wire               in_eom,
  output logic              in_ready,
  input  dsd_pkg::dsd_stat_t stat,
  output dsd_pkg::dsd_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_SKIP,
    S_HEADER,
    S_BODY,
    S_INDEX,
    S_EXPAND
  } state_t;

  state_t state_r, state_nxt;
  logic   eom_pend_r, eom_pend_nxt;
  logic   accept;

  assign in_ready = (state_r != S_EXPAND) && stat.out_free;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt    = state_r;
    eom_pend_nxt = eom_pend_r;
    cmd          = '0;
    case (state_r)
      S_SKIP: begin
        if (accept) begin
          state_nxt = S_HEADER;
        end
      end
      S_HEADER: begin
        if (accept) begin
          if (stat.is_sep) begin
            cmd.hdr_close = 1'b1;
          end else if (stat.is_end) begin
            cmd.hdr_close = 1'b1;
            state_nxt     = S_BODY;
          end else if (stat.hdr_overflow) begin
            cmd.emit_overflow = 1'b1;
          end else begin
            cmd.hdr_write = 1'b1;
          end
        end
      end
      S_BODY: begin
        if (accept) begin
          if (stat.is_esc) begin
            state_nxt = S_INDEX;
          end else begin
            cmd.emit_literal = 1'b1;
          end
        end
      end
      S_INDEX: begin
        if (accept) begin
          if (stat.idx_bad) begin
            cmd.emit_bad = 1'b1;
            state_nxt    = S_BODY;
          end else begin
            cmd.exp_start = 1'b1;
            eom_pend_nxt  = in_eom;
            state_nxt     = S_EXPAND;
          end
        end
      end
      S_EXPAND: begin
        if (stat.out_free) begin
          cmd.exp_emit = 1'b1;
          if (stat.exp_last) begin
            state_nxt = eom_pend_r ? S_SKIP : S_BODY;
          end
        end
      end
      default: begin
        state_nxt = S_SKIP;
      end
    endcase
    // End of message: clear the dictionary state; an expansion still runs out.
    if (accept && in_eom) begin
      cmd.msg_restart = 1'b1;
      if (!cmd.exp_start) begin
        state_nxt = S_SKIP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_SKIP;
      eom_pend_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      eom_pend_r <= eom_pend_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dictionary_substitution_decoder_unit.sv =====
`default_nettype none

// Dictionary substitution decoder. Feed a message one byte per request on the
// in_ channel and mark its final byte with in_tlast. The first byte is dropped;
// the bytes up to '>' are split at ',' into at most MAX_WORDS words of at most
// WORD_BYTES bytes each (empty words vanish). In the body every byte passes
// out as a literal, and '@' followed by an index byte v expands word v-1 byte
// by byte, with out_tlast on the final byte of each expansion and on every
// single-byte result. An index of 0 or beyond the word count gives one result
// with status bad-index; a header byte that overflows a word or the word table
// is dropped and gives one result with status overflow. A '@' as the last
// byte of a message is ignored. Rate: header, '@' and literal bytes go in one
// per cycle whenever the output register is free; an index byte holds off input
// until its word is loaded out, a byte per cycle while the output register is free,
// from the single read port of the dictionary memory. The dictionary is not
// cleared after reset or between messages, so no clearing pass is needed.
module dictionary_substitution_decoder_unit #(
  parameter int MAX_WORDS  = dsd_pkg::MAX_WORDS_DEF,
  parameter int WORD_BYTES = dsd_pkg::WORD_BYTES_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_tvalid,
  output logic       in_tready,
  input  wire  [7:0] in_tdata,   // [7:0] data_byte
  input  wire        in_tlast,   // end_of_message
  output logic       out_tvalid,
  input  wire        out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast,  // last_of_run
  output logic [1:0] out_tuser   // [1:0] status
);

  dsd_pkg::dsd_cmd_t  cmd;
  dsd_pkg::dsd_stat_t stat;

  // Sequence each request: decode phase, issue datapath commands.
  dsd_controller u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_eom   (in_tlast),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Hold the dictionary, header counters and the output register.
  dsd_datapath #(
    .MAX_WORDS  (MAX_WORDS),
    .WORD_BYTES (WORD_BYTES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_byte    (in_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_byte   (out_tdata),
    .out_last   (out_tlast),
    .out_status (out_tuser)
  );

endmodule

`default_nettype wire

// ===== rtl/dsd_checker.sv =====
`default_nettype none

module dsd_checker (
  input wire       clk,
  input wire       rst_n,
  input wire       in_tvalid,
  input wire       in_tready,
  input wire [7:0] in_tdata,
  input wire       in_tlast,
  input wire       out_tvalid,
  input wire       out_tready,
  input wire [7:0] out_tdata,
  input wire       out_tlast,
  input wire [1:0] out_tuser
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tlast) && $stable(out_tuser))
    else $error("stalled result changed");

  // A waiting request holds.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata) && $stable(in_tlast))
    else $error("waiting request changed");

  // No new request is taken while a result is stuck in the output register.
  a_no_take_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("request taken with output blocked");

  // An error result is a single zero byte ending its run.
  a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != dsd_pkg::ST_OK) |->
    (out_tdata == 8'd0) && out_tlast &&
    ((out_tuser == dsd_pkg::ST_BAD_INDEX) || (out_tuser == dsd_pkg::ST_OVERFLOW)))
    else $error("malformed error result");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

endmodule

bind dictionary_substitution_decoder_unit dsd_checker u_chk (.*);

`default_nettype wire

// ===== sim/tb_dictionary_substitution_decoder_unit.sv =====
module tb_dictionary_substitution_decoder_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS   = 340;
  localparam int RX_HOLD_CYCLES = 300;  // long receiver hold-off, fills the block
  localparam int DRAIN_CYCLES   = 40;   // longest word expansion plus margin
  localparam int TIMEOUT_NS     = 10_000_000;
  localparam int DICT_DEPTH     = dsd_pkg::MAX_WORDS_DEF * dsd_pkg::WORD_BYTES_DEF;

  typedef enum logic [1:0] {PH_SKIP, PH_HEADER, PH_BODY, PH_INDEX} msg_phase_t;
  typedef enum int {MSG_NORMAL, MSG_LONG_WORD, MSG_MANY_WORDS, MSG_NOISE} msg_kind_t;

  // One decoded output byte as the block should deliver it.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [1:0] status;
  } out_byte_t;

  // One row of the directed table. A typed row carries its own expectation
  // (none, or one single-byte result) instead of the predicted one.
  typedef struct packed {
    logic [7:0] data;
    logic       eom;
    logic       typed;
    logic       has_res;
    logic [7:0] r_data;
    logic [1:0] r_status;
  } stim_row_t;

  localparam logic TYPED = 1'b1;
  localparam logic PRED  = 1'b0;
  localparam logic ONE   = 1'b1;
  localparam logic NONE  = 1'b0;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;   // [7:0] data_byte
  logic       in_tlast;   // end_of_message
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;  // [7:0] out_byte
  logic       out_tlast;  // last_of_run
  logic [1:0] out_tuser;  // [1:0] status

  // Decoder state mirrored by the predictor.
  msg_phase_t dec_phase;
  logic [7:0] dict_mem [0:DICT_DEPTH-1];
  int         word_len [0:dsd_pkg::MAX_WORDS_DEF-1];
  int         word_count;
  int         write_pos;

  out_byte_t  expected_bytes [$];
  logic [7:0] msg_bytes [$];
  int         fail_count;
  bit         idle_en;
  bit         rx_hold_pending;

  stim_row_t  directed_rows [0:28];

  dictionary_substitution_decoder_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Close the word being collected; empty words and words past the table vanish.
  function automatic void close_word();
    if (write_pos > 0 && word_count < dsd_pkg::MAX_WORDS_DEF) begin
      word_len[word_count] = write_pos;
      word_count++;
    end
    write_pos = 0;
  endfunction

  // Advance the decoder by one accepted byte; queue its results when keep is set.
  function automatic void decode_byte(input logic [7:0] b, input logic eom, input bit keep);
    out_byte_t res [$];
    int        base;
    case (dec_phase)
      PH_SKIP: begin
        dec_phase = PH_HEADER;
      end
      PH_HEADER: begin
        if (b == dsd_pkg::CH_SEPARATOR) begin
          close_word();
        end else if (b == dsd_pkg::CH_END_HEADER) begin
          close_word();
          dec_phase = PH_BODY;
        end else if (word_count >= dsd_pkg::MAX_WORDS_DEF ||
                     write_pos >= dsd_pkg::WORD_BYTES_DEF) begin
          res.push_back({8'h00, 1'b1, dsd_pkg::ST_OVERFLOW});
        end else begin
          dict_mem[word_count * dsd_pkg::WORD_BYTES_DEF + write_pos] = b;
          write_pos++;
        end
      end
      PH_BODY: begin
        if (b == dsd_pkg::CH_ESCAPE) begin
          dec_phase = PH_INDEX;
        end else begin
          res.push_back({b, 1'b1, dsd_pkg::ST_OK});
        end
      end
      default: begin
        dec_phase = PH_BODY;
        if (b == 8'h00 || b > word_count) begin
          res.push_back({8'h00, 1'b1, dsd_pkg::ST_BAD_INDEX});
        end else begin
          base = (b - 1) * dsd_pkg::WORD_BYTES_DEF;
          for (int i = 0; i < word_len[b - 1]; i++) begin
            res.push_back({dict_mem[base + i], i == word_len[b - 1] - 1, dsd_pkg::ST_OK});
          end
        end
      end
    endcase
    // end of message: back to the skip phase with an empty dictionary
    if (eom) begin
      dec_phase  = PH_SKIP;
      word_count = 0;
      write_pos  = 0;
    end
    if (keep) begin
      foreach (res[i]) expected_bytes.push_back(res[i]);
    end
  endfunction

  // Compare one delivered byte against the oldest expectation.
  function automatic void check_result(input logic [7:0] d, input logic l, input logic [1:0] s);
    out_byte_t e;
    if (expected_bytes.size() == 0) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("unexpected result: byte %02h last %0d status %0d", d, l, s);
      end
      return;
    end
    e = expected_bytes.pop_front();
    if (e.data !== d || e.last !== l || e.status !== s) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("mismatch: expected byte %02h last %0d status %0d, got byte %02h last %0d status %0d",
                 e.data, e.last, e.status, d, l, s);
      end
    end
  endfunction

  // Offer one request after a random gap; predict once it is accepted.
  task automatic send_request(input logic [7:0] b, input logic eom, input bit keep);
    int gap;
    gap = idle_en ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eom;
    do @(posedge clk); while (!in_tready);
    decode_byte(b, eom, keep);
  endtask

  // Build one message: skip byte, header, body. Mostly well-formed, small words.
  task automatic build_message(input msg_kind_t kind);
    int         n_words;
    int         lo;
    int         hi;
    int         len;
    int         valid;
    logic [7:0] b;
    msg_bytes.delete();
    msg_bytes.push_back(8'($urandom_range(0, 255)));
    if (kind == MSG_NOISE) begin
      repeat ($urandom_range(1, 8)) msg_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end
    case (kind)
      MSG_LONG_WORD: begin
        n_words = 1;
        lo = dsd_pkg::WORD_BYTES_DEF + 1;
        hi = dsd_pkg::WORD_BYTES_DEF + 3;
      end
      MSG_MANY_WORDS: begin
        n_words = $urandom_range(dsd_pkg::MAX_WORDS_DEF + 1, dsd_pkg::MAX_WORDS_DEF + 2);
        lo = 1;
        hi = 2;
      end
      default: begin
        n_words = $urandom_range(0, 6);
        lo = 1;
        hi = 6;
      end
    endcase
    for (int w = 0; w < n_words; w++) begin
      // stray comma makes an empty word that must collapse
      if ($urandom_range(0, 3) == 0) msg_bytes.push_back(dsd_pkg::CH_SEPARATOR);
      if (kind == MSG_NORMAL && $urandom_range(0, 7) == 0) begin
        len = dsd_pkg::WORD_BYTES_DEF;
      end else begin
        len = $urandom_range(lo, hi);
      end
      repeat (len) begin
        do b = 8'($urandom_range(0, 255));
        while (b == dsd_pkg::CH_SEPARATOR || b == dsd_pkg::CH_END_HEADER);
        msg_bytes.push_back(b);
      end
      if (w != n_words - 1 || $urandom_range(0, 1)) msg_bytes.push_back(dsd_pkg::CH_SEPARATOR);
    end
    msg_bytes.push_back(dsd_pkg::CH_END_HEADER);
    valid = (n_words > dsd_pkg::MAX_WORDS_DEF) ? dsd_pkg::MAX_WORDS_DEF : n_words;
    repeat ($urandom_range(3, 14)) begin
      if ($urandom_range(0, 2) == 0) begin
        msg_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
        msg_bytes.push_back(dsd_pkg::CH_ESCAPE);
        if (valid > 0 && $urandom_range(0, 4) != 0) begin
          msg_bytes.push_back(8'($urandom_range(1, valid)));
        end else begin
          msg_bytes.push_back(8'($urandom_range(0, 255)));
        end
      end
    end
    // dangling escape on the final byte now and then
    if ($urandom_range(0, 5) == 0) msg_bytes.push_back(dsd_pkg::CH_ESCAPE);
  endtask

  // Receiver: random stalls per result, one long hold-off on request.
  initial begin
    int stall;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (rx_hold_pending) begin
        rx_hold_pending = 1'b0;
        out_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
      end
      stall = idle_en ? $urandom_range(0, 4) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      check_result(out_tdata, out_tlast, out_tuser);
    end
  end

  // Main sequence: reset, directed table, random messages, drain.
  initial begin
    stim_row_t row;
    msg_kind_t kind;
    int        sent;
    int        msg;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= 8'h00;
    in_tlast   <= 1'b0;
    fail_count      = 0;
    idle_en         = 1'b1;
    rx_hold_pending = 1'b0;
    dec_phase       = PH_SKIP;
    word_count      = 0;
    write_pos       = 0;
    foreach (dict_mem[i]) dict_mem[i] = 8'h00;
    foreach (word_len[i]) word_len[i] = 0;

    directed_rows = '{
      // after reset the first byte is dropped; a leading comma adds no word
      {8'hFF,                  1'b0, TYPED, NONE, 8'h00, dsd_pkg::ST_OK},
      {dsd_pkg::CH_SEPARATOR,  1'b0, TYPED, NONE, 8'h00, dsd_pkg::ST_OK},
      // word 1 = zero byte and a stray escape; double comma; word 2 = FF
      {8'h00,                  1'b0, PRED,  NONE, 8'h00, dsd_pkg::ST_OK},
      {dsd_pkg::CH_ESCAPE,     1'b0, PRED,  NONE, 8'h00, dsd_pkg::ST_OK},
      {dsd_pkg::CH_SEPARATOR,  1'b0, PRED,  NONE, 8'h00, dsd_pkg::ST_OK},
      {dsd_pkg::CH_SEPARATOR,  1'b0, PRED,  NONE, 8'h00, dsd_pkg::ST_OK},
      {8'hFF,                  1'b0, PRED,  NONE, 8'h00, dsd_pkg::ST_OK},
      {dsd_pkg::CH_END_HEADER, 1'b0, PRED,  NONE, 8'h00, dsd_pkg::ST_OK},
      // literal extremes, then stray header markers as literals
      {8'h00,                  1'b0, TYPED, ONE,  8'h00, dsd_pkg::ST_OK},
      {8'hFF,                  1'b0, TYPED, ONE,  8'hFF, dsd_pkg::ST_OK},
      {dsd_pkg::CH_END_HEADER, 1'b0, PRED,  NONE, 8'h00, dsd_pkg::ST_OK},
      {dsd_pkg::CH_SEPARATOR,  1'b0, PRED,  NONE, 8'h00, dsd_pkg::ST_OK},
      // expand word 1, then index zero, index one past the count, and word 2
      {dsd_pkg::CH_ESCAPE,     1'b0, PRED,  NONE, 8'h00, dsd_pkg::ST_OK},
      {8'h01,                  1'b0, PRED,  NONE, 8'h00, dsd_pkg::ST_OK},
      {dsd_pkg::CH_ESCAPE,     1'b0, PRED,  NONE, 8'h00, dsd_pkg::ST_OK},
      {8'h00,                  1'b0, TYPED, ONE,  8'h00, dsd_pkg::ST_BAD_INDEX},
      {dsd_pkg::CH_ESCAPE,     1'b0, PRED,  NONE, 8'h00, dsd_pkg::ST_OK},
      {8'h03,                  1'b0, TYPED, ONE,  8'h00, dsd_pkg::ST_BAD_INDEX},
      {dsd_pkg::CH_ESCAPE,     1'b0, PRED,  NONE, 8'h00, dsd_pkg::ST_OK},
      {8'h02,                  1'b0, PRED,  NONE, 8'h00, dsd_pkg::ST_OK},
      // escape as the final byte is ignored
      {dsd_pkg::CH_ESCAPE,     1'b1, TYPED, NONE, 8'h00, dsd_pkg::ST_OK},
      // message ends inside the header, then one that ends on its skip byte
      {8'h41,                  1'b0, PRED,  NONE, 8'h00, dsd_pkg::ST_OK},
      {8'h61,                  1'b1, PRED,  NONE, 8'h00, dsd_pkg::ST_OK},
      {8'h00,                  1'b1, PRED,  NONE, 8'h00, dsd_pkg::ST_OK},
      // empty dictionary: any index is bad
      {8'h10,                  1'b0, PRED,  NONE, 8'h00, dsd_pkg::ST_OK},
      {dsd_pkg::CH_END_HEADER, 1'b0, PRED,  NONE, 8'h00, dsd_pkg::ST_OK},
      {dsd_pkg::CH_ESCAPE,     1'b0, PRED,  NONE, 8'h00, dsd_pkg::ST_OK},
      {8'hFF,                  1'b0, TYPED, ONE,  8'h00, dsd_pkg::ST_BAD_INDEX},
      {8'h7E,                  1'b1, PRED,  NONE, 8'h00, dsd_pkg::ST_OK}
    };

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_request(row.data, row.eom, !row.typed);
      if (row.typed && row.has_res) begin
        expected_bytes.push_back({row.r_data, 1'b1, row.r_status});
      end
    end

    // Random messages; every fourth one runs with no idling on either side.
    sent = 0;
    msg  = 0;
    while (sent < RANDOM_ITEMS) begin
      idle_en = (msg % 4) != 3;
      // hold the receiver off while long words expand, so input stalls
      if (msg == 0) rx_hold_pending = 1'b1;
      // pause the sender until every expected byte has come out
      if (msg == 4) begin
        in_tvalid <= 1'b0;
        do @(posedge clk); while (expected_bytes.size() != 0);
      end
      case (msg)
        0: kind = MSG_LONG_WORD;
        1: kind = MSG_MANY_WORDS;
        default: begin
          case ($urandom_range(0, 9))
            0: kind = MSG_LONG_WORD;
            1: kind = MSG_MANY_WORDS;
            2: kind = MSG_NOISE;
            default: kind = MSG_NORMAL;
          endcase
        end
      endcase
      build_message(kind);
      foreach (msg_bytes[i]) begin
        send_request(msg_bytes[i], i == msg_bytes.size() - 1, 1'b1);
      end
      sent += msg_bytes.size();
      msg++;
    end

    // Drain: wait for outstanding bytes, then watch for strays.
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_bytes.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_dictionary_substitution_decoder_unit: PASS");
    end else begin
      $display("tb_dictionary_substitution_decoder_unit: FAIL");
    end
    $finish;
  end

  // Watchdog on a hung handshake.
  initial begin
    #TIMEOUT_NS;
    $display("tb_dictionary_substitution_decoder_unit: FAIL");
    $finish;
  end

endmodule
